/* design/cfp_pkg.sv */
// ----------------------------------------------------------------------------
// cfp_pkg: command frame parser shared definitions
// Frame bytes, register indexes, parser phases, status codes and the
// request and result item types.
// ----------------------------------------------------------------------------
package cfp_pkg;

  localparam logic [7:0]  HeaderByte   = 8'hBB;
  localparam logic [7:0]  EndByte      = 8'h7E;
  localparam logic [15:0] MaxLengthRst = 16'd256;
  localparam logic [15:0] TimeoutRst   = 16'd80;
  localparam logic [15:0] TickSat      = 16'hFFFF;
  localparam int          CfgIdxW      = 8;
  localparam int          CfgDataW     = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxLength    = 8'd0,
    CfgTimeoutTicks = 8'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PhHunt,
    PhType,
    PhCmd,
    PhLenH,
    PhLenL,
    PhPayload,
    PhCheck,
    PhEnd
  } phase_e;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StBadSum  = 3'd1,
    StBadEnd  = 3'd2,
    StTooLong = 3'd3,
    StTimeout = 3'd4
  } status_e;

  typedef enum logic {
    KindPayload  = 1'b0,
    KindFrameEnd = 1'b1
  } kind_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  frame_type;
    logic [7:0]  frame_command;
    logic [15:0] frame_length;
    logic [2:0]  status;
  } res_t;

endpackage

/* design/cfp_if.sv */
// ----------------------------------------------------------------------------
// cfp channel interfaces
// Valid/ready channels for request items, result items and register writes.
// ----------------------------------------------------------------------------
interface cfp_req_if;
  logic          valid;
  logic          ready;
  cfp_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cfp_res_if;
  logic          valid;
  logic          ready;
  cfp_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cfp_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [cfp_pkg::CfgIdxW-1:0]  index;
  logic [cfp_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* design/cfp_parser.sv */
// ----------------------------------------------------------------------------
// cfp_parser: input register and per-item frame state update
// Registers one request item, then updates the frame state and forms at
// most one result from the registered item once the result buffer has room.
// ----------------------------------------------------------------------------
module cfp_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  cfp_req_if.sink              req_i,
  input  logic [15:0]          max_length_i,
  input  logic [15:0]          timeout_ticks_i,
  input  logic                 res_ready_i,
  output logic                 res_valid_o,
  output cfp_pkg::res_t        res_o
);

  logic             s1_valid_q;
  cfp_pkg::req_t    req_q;
  logic             fire;

  cfp_pkg::phase_e  phase_q, phase_d;
  logic [7:0]       type_q, type_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [15:0]      length_q, length_d;
  logic [15:0]      seen_q, seen_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       chk_q, chk_d;
  logic [15:0]      ticks_q, ticks_d;

  logic             end_hit;
  cfp_pkg::status_e end_status;
  logic             byte_hit;

  assign req_i.ready = !s1_valid_q || res_ready_i;
  assign fire        = s1_valid_q && res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      req_q <= req_i.data;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    type_d     = type_q;
    cmd_d      = cmd_q;
    length_d   = length_q;
    seen_d     = seen_q;
    sum_d      = sum_q;
    chk_d      = chk_q;
    ticks_d    = ticks_q;
    end_hit    = 1'b0;
    end_status = cfp_pkg::StOk;
    byte_hit   = 1'b0;

    if (fire) begin
      if (req_q.req_type) begin
        // ticks only count once a header has been seen
        if (phase_q != cfp_pkg::PhHunt) begin
          ticks_d = (ticks_q == cfp_pkg::TickSat) ? ticks_q : ticks_q + 16'd1;
          if (ticks_d >= timeout_ticks_i) begin
            end_hit    = 1'b1;
            end_status = cfp_pkg::StTimeout;
          end
        end
      end else begin
        case (phase_q)
          cfp_pkg::PhHunt: begin
            if (req_q.rx_byte == cfp_pkg::HeaderByte) begin
              type_d   = '0;
              cmd_d    = '0;
              length_d = '0;
              seen_d   = '0;
              sum_d    = '0;
              chk_d    = '0;
              ticks_d  = '0;
              phase_d  = cfp_pkg::PhType;
            end
          end
          cfp_pkg::PhType: begin
            type_d  = req_q.rx_byte;
            sum_d   = sum_q + req_q.rx_byte;
            phase_d = cfp_pkg::PhCmd;
          end
          cfp_pkg::PhCmd: begin
            cmd_d   = req_q.rx_byte;
            sum_d   = sum_q + req_q.rx_byte;
            phase_d = cfp_pkg::PhLenH;
          end
          cfp_pkg::PhLenH: begin
            length_d = {req_q.rx_byte, 8'h00};
            sum_d    = sum_q + req_q.rx_byte;
            phase_d  = cfp_pkg::PhLenL;
          end
          cfp_pkg::PhLenL: begin
            length_d = {length_q[15:8], req_q.rx_byte};
            sum_d    = sum_q + req_q.rx_byte;
            seen_d   = '0;
            if (length_d > max_length_i) begin
              end_hit    = 1'b1;
              end_status = cfp_pkg::StTooLong;
            end else begin
              // zero length skips straight to the checksum byte
              phase_d = (length_d == 16'd0) ? cfp_pkg::PhCheck : cfp_pkg::PhPayload;
            end
          end
          cfp_pkg::PhPayload: begin
            sum_d    = sum_q + req_q.rx_byte;
            seen_d   = seen_q + 16'd1;
            byte_hit = 1'b1;
            if (seen_d >= length_q) begin
              phase_d = cfp_pkg::PhCheck;
            end
          end
          cfp_pkg::PhCheck: begin
            chk_d   = req_q.rx_byte;
            phase_d = cfp_pkg::PhEnd;
          end
          default: begin
            // end byte is judged before the checksum
            end_hit = 1'b1;
            if (req_q.rx_byte != cfp_pkg::EndByte) begin
              end_status = cfp_pkg::StBadEnd;
            end else if (sum_q != chk_q) begin
              end_status = cfp_pkg::StBadSum;
            end else begin
              end_status = cfp_pkg::StOk;
            end
          end
        endcase
      end
      if (end_hit) begin
        phase_d = cfp_pkg::PhHunt;
      end
    end
  end

  always_comb begin
    res_valid_o = end_hit || byte_hit;
    res_o       = '0;
    if (end_hit) begin
      res_o.result_kind   = cfp_pkg::KindFrameEnd;
      res_o.frame_type    = type_d;
      res_o.frame_command = cmd_d;
      res_o.frame_length  = length_d;
      res_o.status        = end_status;
    end else if (byte_hit) begin
      res_o.result_kind  = cfp_pkg::KindPayload;
      res_o.payload_byte = req_q.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= cfp_pkg::PhHunt;
      type_q   <= '0;
      cmd_q    <= '0;
      length_q <= '0;
      seen_q   <= '0;
      sum_q    <= '0;
      chk_q    <= '0;
      ticks_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      type_q   <= type_d;
      cmd_q    <= cmd_d;
      length_q <= length_d;
      seen_q   <= seen_d;
      sum_q    <= sum_d;
      chk_q    <= chk_d;
      ticks_q  <= ticks_d;
    end
  end

`ifndef SYNTH
  a_payload_only_in_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && byte_hit) |-> (phase_q == cfp_pkg::PhPayload))
    else $error("payload transfer outside payload phase");

  a_end_returns_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_hit |=> (phase_q == cfp_pkg::PhHunt))
    else $error("frame end did not return to hunting");

  a_seen_below_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == cfp_pkg::PhPayload) |-> (seen_q < length_q))
    else $error("payload count reached length while still in payload phase");

  a_result_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> fire)
    else $error("result formed without a registered item");
`endif

endmodule

/* design/cfp_out_fifo.sv */
// ----------------------------------------------------------------------------
// cfp_out_fifo: two-entry result buffer
// Holds finished results so the parser keeps taking items while the
// receiver stalls; ready toward the parser comes from the fill count only.
// ----------------------------------------------------------------------------
module cfp_out_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cfp_pkg::res_t push_data_i,
  output logic          not_full_o,
  cfp_res_if.source     res_o
);

  cfp_pkg::res_t mem_q [2];
  logic          wr_ptr_q;
  logic          rd_ptr_q;
  logic [1:0]    count_q;
  logic          pop;

  assign not_full_o  = (count_q != 2'd2);
  assign res_o.valid = (count_q != 2'd0);
  assign res_o.data  = mem_q[rd_ptr_q];
  assign pop         = res_o.valid && res_o.ready;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> not_full_o)
    else $error("result pushed into a full buffer");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result buffer count overflow");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop) |=> (count_q == $past(count_q) + 2'd1))
    else $error("pushed result not counted");
`endif

endmodule

/* design/command_frame_parser.sv */
// ----------------------------------------------------------------------------
// command_frame_parser: header/length/checksum frame parser
// Parses 0xBB, type, command, length (big endian), payload, checksum, 0x7E.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one item per transfer: a received byte (req_type 0) or a
//   timer tick (req_type 1). res_o carries payload bytes as they arrive and
//   one frame-end status per frame. cfg_i writes max_length (index 0) and
//   timeout_ticks (index 1); other indexes are dropped. cfg_i is always
//   ready and must only be written while no item is in flight.
//   An item is held in the input register; the state update then works on
//   it and writes any result into the result buffer, from which res_o
//   shows it. The update waits while the buffer is full. Throughput: one
//   item per cycle while the result buffer has room, set by the state
//   update between the input register and the buffer.
//   Reset returns the parser to header hunting and loads max_length 256 and
//   timeout_ticks 80. When the receiver stalls, the two-entry result buffer
//   fills and req_i.ready drops only once it is full and an item is pending.
// ----------------------------------------------------------------------------
module command_frame_parser (
  input  logic      clk_i,
  input  logic      rst_ni,
  cfp_req_if.sink   req_i,
  cfp_res_if.source res_o,
  cfp_cfg_if.sink   cfg_i
);

  logic [15:0]   max_length_q;
  logic [15:0]   timeout_ticks_q;
  logic          fifo_not_full;
  logic          res_valid;
  cfp_pkg::res_t res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q    <= cfp_pkg::MaxLengthRst;
      timeout_ticks_q <= cfp_pkg::TimeoutRst;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == cfp_pkg::CfgMaxLength) begin
        max_length_q <= cfg_i.data;
      end else if (cfg_i.index == cfp_pkg::CfgTimeoutTicks) begin
        timeout_ticks_q <= cfg_i.data;
      end
    end
  end

  cfp_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (req_i),
    .max_length_i    (max_length_q),
    .timeout_ticks_i (timeout_ticks_q),
    .res_ready_i     (fifo_not_full),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  cfp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .not_full_o  (fifo_not_full),
    .res_o       (res_o)
  );

endmodule

/* tb/sv/command_frame_parser_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_frame_parser_test: self-checking bench for the command frame parser
// Feeds received bytes and timer ticks through the request channel, writes
// the length limit and tick budget between runs of frames, and checks every
// payload byte and frame-end status against a cycle-free parser model kept
// in the bench or the directed table. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module command_frame_parser_test;

  localparam logic ReqByte = 1'b0;
  localparam logic ReqTick = 1'b1;
  localparam logic [cfp_pkg::CfgIdxW-1:0] CfgIdxUnused = 8'hFF;
  localparam logic [15:0] LenTop = 16'hFFFF;
  localparam cfp_pkg::res_t NoRes = '0;
  localparam int NumSettings = 7;
  localparam logic [15:0] SetMaxLen [NumSettings] =
    '{cfp_pkg::MaxLengthRst, 16'd0, 16'hFFFF, 16'd8, 16'd1000, 16'd3, 16'd16};
  localparam logic [15:0] SetTicks [NumSettings] =
    '{cfp_pkg::TimeoutRst, 16'd1, 16'hFFFF, 16'd4, 16'd30, 16'd200, 16'd12};

  typedef struct packed {
    cfp_pkg::req_t item;
    logic          typed;
    cfp_pkg::res_t want;
  } dir_row_t;

  // Short frames at reset limits; the tick budget is lowered to 2 beforehand.
  localparam dir_row_t DirRows [26] = '{
    '{'{ReqTick, 8'hFF}, 1'b0, NoRes},   // tick while hunting
    '{'{ReqByte, 8'h00}, 1'b0, NoRes},   // stray byte
    '{'{ReqByte, cfp_pkg::HeaderByte}, 1'b0, NoRes},
    '{'{ReqByte, 8'hFF}, 1'b0, NoRes},
    '{'{ReqByte, 8'h00}, 1'b0, NoRes},
    '{'{ReqByte, 8'h01}, 1'b0, NoRes},
    '{'{ReqByte, 8'h01}, 1'b1,
      '{cfp_pkg::KindFrameEnd, 8'h00, 8'hFF, 8'h00, 16'h0101, cfp_pkg::StTooLong}},
    '{'{ReqByte, cfp_pkg::HeaderByte}, 1'b0, NoRes},
    '{'{ReqByte, 8'h00}, 1'b0, NoRes},
    '{'{ReqByte, 8'hFF}, 1'b0, NoRes},
    '{'{ReqByte, 8'h00}, 1'b0, NoRes},
    '{'{ReqByte, 8'h00}, 1'b0, NoRes},   // zero length: checksum next
    '{'{ReqByte, 8'hFF}, 1'b0, NoRes},
    '{'{ReqByte, cfp_pkg::EndByte}, 1'b1,
      '{cfp_pkg::KindFrameEnd, 8'h00, 8'h00, 8'hFF, 16'h0000, cfp_pkg::StOk}},
    '{'{ReqByte, cfp_pkg::HeaderByte}, 1'b0, NoRes},
    '{'{ReqByte, 8'h12}, 1'b0, NoRes},
    '{'{ReqByte, cfp_pkg::HeaderByte}, 1'b0, NoRes},   // header value as command
    '{'{ReqByte, 8'h00}, 1'b0, NoRes},
    '{'{ReqByte, 8'h01}, 1'b0, NoRes},
    '{'{ReqByte, cfp_pkg::HeaderByte}, 1'b1,
      '{cfp_pkg::KindPayload, cfp_pkg::HeaderByte, 8'h00, 8'h00, 16'h0000,
        cfp_pkg::StOk}},
    '{'{ReqByte, 8'h00}, 1'b0, NoRes},   // checksum should be 0x89
    '{'{ReqByte, cfp_pkg::EndByte}, 1'b1,
      '{cfp_pkg::KindFrameEnd, 8'h00, 8'h12, cfp_pkg::HeaderByte, 16'h0001,
        cfp_pkg::StBadSum}},
    '{'{ReqByte, cfp_pkg::HeaderByte}, 1'b0, NoRes},
    '{'{ReqByte, 8'h05}, 1'b0, NoRes},
    '{'{ReqTick, 8'h00}, 1'b0, NoRes},
    '{'{ReqTick, 8'h55}, 1'b1,
      '{cfp_pkg::KindFrameEnd, 8'h00, 8'h05, 8'h00, 16'h0000, cfp_pkg::StTimeout}}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cfp_req_if req_ch ();
  cfp_res_if res_ch ();
  cfp_cfg_if cfg_ch ();

  command_frame_parser u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Parser model state and its copy of the registers.
  cfp_pkg::phase_e frm_phase = cfp_pkg::PhHunt;
  logic [7:0]      frm_type = '0;
  logic [7:0]      frm_cmd = '0;
  logic [15:0]     frm_len = '0;
  logic [15:0]     pay_count = '0;
  logic [7:0]      sum_acc = '0;
  logic [7:0]      rx_sum = '0;
  logic [15:0]     tick_count = '0;
  logic [15:0]     lim_len = cfp_pkg::MaxLengthRst;
  logic [15:0]     lim_ticks = cfp_pkg::TimeoutRst;

  cfp_pkg::res_t frame_results_due [$];

  logic          row_typed = 1'b0;
  cfp_pkg::res_t row_want = NoRes;
  bit            gaps_on = 1'b1;
  bit            stalls_on = 1'b1;
  logic          res_take = 1'b1;
  int            stall_left = 0;

  int err_count = 0;
  int items_sent = 0;
  int regs_written = 0;
  int payload_seen = 0;
  int ends_by_status [5] = '{0, 0, 0, 0, 0};

  assign res_ch.ready = res_take;

  function automatic cfp_pkg::res_t close_frame(input cfp_pkg::status_e st);
    cfp_pkg::res_t r;
    r = NoRes;
    r.result_kind   = cfp_pkg::KindFrameEnd;
    r.frame_type    = frm_type;
    r.frame_command = frm_cmd;
    r.frame_length  = frm_len;
    r.status        = st;
    frm_phase = cfp_pkg::PhHunt;
    return r;
  endfunction

  // Advance the parser model by one item; return 1 when it yields a result.
  function automatic bit parse_item(input cfp_pkg::req_t item, output cfp_pkg::res_t r);
    bit emit;
    logic [7:0] b;
    emit = 1'b0;
    r = NoRes;
    b = item.rx_byte;
    if (item.req_type == ReqTick) begin
      if (frm_phase != cfp_pkg::PhHunt) begin
        if (tick_count != LenTop) tick_count++;
        if (tick_count >= lim_ticks) begin
          emit = 1'b1;
          r = close_frame(cfp_pkg::StTimeout);
        end
      end
    end else begin
      case (frm_phase)
        cfp_pkg::PhHunt: begin
          if (b == cfp_pkg::HeaderByte) begin
            frm_type = '0;
            frm_cmd = '0;
            frm_len = '0;
            pay_count = '0;
            sum_acc = '0;
            rx_sum = '0;
            tick_count = '0;
            frm_phase = cfp_pkg::PhType;
          end
        end
        cfp_pkg::PhType: begin
          frm_type = b;
          sum_acc += b;
          frm_phase = cfp_pkg::PhCmd;
        end
        cfp_pkg::PhCmd: begin
          frm_cmd = b;
          sum_acc += b;
          frm_phase = cfp_pkg::PhLenH;
        end
        cfp_pkg::PhLenH: begin
          frm_len = {b, 8'h00};
          sum_acc += b;
          frm_phase = cfp_pkg::PhLenL;
        end
        cfp_pkg::PhLenL: begin
          frm_len[7:0] = b;
          sum_acc += b;
          if (frm_len > lim_len) begin
            emit = 1'b1;
            r = close_frame(cfp_pkg::StTooLong);
          end else begin
            pay_count = '0;
            frm_phase = (frm_len == 16'd0) ? cfp_pkg::PhCheck : cfp_pkg::PhPayload;
          end
        end
        cfp_pkg::PhPayload: begin
          sum_acc += b;
          pay_count++;
          if (pay_count >= frm_len) frm_phase = cfp_pkg::PhCheck;
          emit = 1'b1;
          r.result_kind = cfp_pkg::KindPayload;
          r.payload_byte = b;
        end
        cfp_pkg::PhCheck: begin
          rx_sum = b;
          frm_phase = cfp_pkg::PhEnd;
        end
        default: begin
          emit = 1'b1;
          // end byte is judged before the checksum
          if (b != cfp_pkg::EndByte) r = close_frame(cfp_pkg::StBadEnd);
          else if (sum_acc != rx_sum) r = close_frame(cfp_pkg::StBadSum);
          else r = close_frame(cfp_pkg::StOk);
        end
      endcase
    end
    return emit;
  endfunction

  task automatic flag_field(input string name, input logic [15:0] want,
                            input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      err_count++;
    end
  endtask

  task automatic check_result(input cfp_pkg::res_t got);
    cfp_pkg::res_t want;
    if (frame_results_due.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      err_count++;
    end else begin
      want = frame_results_due.pop_front();
      flag_field("result_kind", 16'(want.result_kind), 16'(got.result_kind));
      flag_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
      flag_field("frame_type", 16'(want.frame_type), 16'(got.frame_type));
      flag_field("frame_command", 16'(want.frame_command), 16'(got.frame_command));
      flag_field("frame_length", want.frame_length, got.frame_length);
      flag_field("status", 16'(want.status), 16'(got.status));
      if (want.result_kind == cfp_pkg::KindPayload) payload_seen++;
      else ends_by_status[want.status]++;
    end
  endtask

  // Sample all three channels at the rising edge.
  always @(posedge clk) begin
    cfp_pkg::res_t predicted;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          cfp_pkg::CfgMaxLength:    lim_len = cfg_ch.data;
          cfp_pkg::CfgTimeoutTicks: lim_ticks = cfg_ch.data;
          default: ;
        endcase
      end
      if (res_ch.valid && res_ch.ready) check_result(res_ch.data);
      if (req_ch.valid && req_ch.ready) begin
        if (parse_item(req_ch.data, predicted))
          frame_results_due = {frame_results_due, (row_typed ? row_want : predicted)};
      end
    end
  end

  // Result-side back pressure: mostly short stalls, now and then a long one.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      res_take <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left <= ($urandom_range(0, 11) == 0) ? $urandom_range(8, 40)
                                                 : $urandom_range(0, 2);
      res_take <= 1'b0;
    end else begin
      res_take <= 1'b1;
    end
  end

  task automatic send_item(input cfp_pkg::req_t item, input logic typed,
                           input cfp_pkg::res_t want);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
      repeat (gap) @(negedge clk);
    end
    req_ch.data = item;
    row_typed = typed;
    row_want = want;
    req_ch.valid = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    req_ch.valid = 1'b0;
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item({ReqByte, b}, 1'b0, NoRes);
  endtask

  task automatic send_tick();
    logic [7:0] junk;
    junk = 8'($urandom);
    send_item({ReqTick, junk}, 1'b0, NoRes);
  endtask

  task automatic write_reg(input logic [cfp_pkg::CfgIdxW-1:0] idx,
                           input logic [15:0] val);
    cfg_ch.index = idx;
    cfg_ch.data = val;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    regs_written++;
  endtask

  // Hold until every result is out, then let items without a result drain.
  task automatic settle();
    while (frame_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [7:0]  frame [$];
    logic [7:0]  ftype;
    logic [7:0]  fcmd;
    logic [7:0]  pb;
    logic [7:0]  noise;
    logic [7:0]  fsum;
    logic [7:0]  sum_byte;
    logic [7:0]  end_byte;
    logic [15:0] flen;
    int unsigned cap;
    int unsigned fault;
    int unsigned cut;
    int          phase_stop;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    write_reg(cfp_pkg::CfgTimeoutTicks, 16'd2);
    for (int i = 0; i < $size(DirRows); i++)
      send_item(DirRows[i].item, DirRows[i].typed, DirRows[i].want);
    settle();

    for (int p = 0; p < NumSettings; p++) begin
      write_reg(cfp_pkg::CfgMaxLength, SetMaxLen[p]);
      write_reg(cfp_pkg::CfgTimeoutTicks, SetTicks[p]);
      if (p == 3) write_reg(CfgIdxUnused, 16'h0000);
      stalls_on = p[0];
      phase_stop = items_sent + 190;
      while (items_sent < phase_stop) begin
        gaps_on = ($urandom_range(0, 2) != 0);
        ftype = 8'($urandom);
        fcmd = 8'($urandom);
        cap = (lim_len < 16'd12) ? lim_len : 12;
        case ($urandom_range(0, 9))
          0: begin
            flen = 16'($urandom);
            if (flen <= lim_len) flen = flen & 16'h000F;
          end
          1: flen = (lim_len == LenTop) ? 16'd0 : lim_len + 16'd1;
          default: flen = 16'($urandom_range(0, cap));
        endcase
        // 0 bad checksum, 1 bad end, 2 both, 3 cut short, others clean
        fault = $urandom_range(0, 15);
        if (fault == 3 && lim_ticks > 16'd300) fault = 15;
        fsum = ftype + fcmd + flen[15:8] + flen[7:0];
        frame = '{cfp_pkg::HeaderByte, ftype, fcmd, flen[15:8], flen[7:0]};
        if (flen <= lim_len) begin
          for (int i = 0; i < flen; i++) begin
            pb = 8'($urandom);
            frame = {frame, pb};
            fsum += pb;
          end
          sum_byte = fsum;
          if (fault == 0 || fault == 2) sum_byte = fsum ^ 8'($urandom_range(1, 255));
          end_byte = cfp_pkg::EndByte;
          if (fault == 1 || fault == 2)
            end_byte = cfp_pkg::EndByte ^ 8'($urandom_range(1, 255));
          frame = {frame, sum_byte, end_byte};
        end
        cut = (fault == 3) ? $urandom_range(1, frame.size() - 1) : frame.size();
        for (int i = 0; i < cut; i++) begin
          if ($urandom_range(0, 14) == 0) send_tick();
          send_byte(frame[i]);
        end
        // abandon the partial frame by running out its tick budget
        if (fault == 3)
          while (frm_phase != cfp_pkg::PhHunt) send_tick();
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 1) == 0) begin
              send_tick();
            end else begin
              noise = 8'($urandom);
              if (noise == cfp_pkg::HeaderByte) noise = ~noise;
              send_byte(noise);
            end
          end
        end
        if ($urandom_range(0, 39) == 0) settle();
      end
      settle();
    end

    settle();
    $display("Sent %0d items and %0d register writes over %0d limit settings",
             items_sent, regs_written, NumSettings + 1);
    $display("Checked %0d payload bytes; frame ends ok %0d, bad sum %0d, bad end %0d,",
             payload_seen, ends_by_status[cfp_pkg::StOk],
             ends_by_status[cfp_pkg::StBadSum], ends_by_status[cfp_pkg::StBadEnd]);
    $display("  too long %0d, timeout %0d",
             ends_by_status[cfp_pkg::StTooLong], ends_by_status[cfp_pkg::StTimeout]);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("Some tests failed");
    $finish;
  end

endmodule

/* sim.f */
design/cfp_pkg.sv
design/cfp_if.sv
design/cfp_parser.sv
design/cfp_out_fifo.sv
design/command_frame_parser.sv
tb/sv/command_frame_parser_test.sv
